>>> rtl/core/cldbr_pkg.sv
// ----------------------------------------------------------------------------
// cldbr_pkg
// Shared types and constants for the double-buffered character LCD refresher.
// ----------------------------------------------------------------------------
package cldbr_pkg;

    localparam int unsigned DEF_COLUMNS = 16;
    localparam int unsigned DEF_ROWS    = 2;
    localparam int unsigned STAGE_LINES = 2;

    localparam logic [7:0] BLANK = 8'h20;

    // item modes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_COMMIT = 2'd2;

    // display command kinds
    localparam logic CMD_SET_CURSOR = 1'b0;
    localparam logic CMD_WRITE_CHAR = 1'b1;

    typedef enum logic [1:0] {
        SEQ_IDLE    = 2'd0,
        SEQ_SET_ROW = 2'd1,
        SEQ_WRITE   = 2'd2
    } seq_state_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       line_select;
        logic [7:0] char_code;
        logic       center_text;
    } in_item_t;

    typedef struct packed {
        logic       cmd_kind;
        logic       cursor_row;
        logic [7:0] char_out;
    } out_item_t;

endpackage

>>> rtl/core/cldbr_in_if.sv
// ----------------------------------------------------------------------------
// cldbr_in_if
// Valid/ready channel carrying refresher input items.
// ----------------------------------------------------------------------------
interface cldbr_in_if;
    import cldbr_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/cldbr_out_if.sv
// ----------------------------------------------------------------------------
// cldbr_out_if
// Valid/ready channel carrying display commands.
// ----------------------------------------------------------------------------
interface cldbr_out_if;
    import cldbr_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/char_lcd_double_buffer_refresh.sv
// ----------------------------------------------------------------------------
// char_lcd_double_buffer_refresh
// Double-buffered refresh sequencer for a ROWS x COLUMNS character display.
// ----------------------------------------------------------------------------
// Takes one item per cycle with no bubbles as long as the display side keeps
// ready high. An accepted item lands in an input register and is processed
// from there once the result register is empty or being taken: appends,
// commits (full-line formatting with optional centering) and refresher ticks
// are each a single register update, and a tick that makes a command passes
// it from the input register into the result register. The only thing that
// holds up input is a full result register that the display has not taken;
// items that make no command still wait behind it to keep order. The waiting
// and active buffers reset to blanks; there is no power-up message and no LCD
// init sequence.
// ----------------------------------------------------------------------------
module char_lcd_double_buffer_refresh #(
    parameter int unsigned COLUMNS = cldbr_pkg::DEF_COLUMNS,
    parameter int unsigned ROWS    = cldbr_pkg::DEF_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    cldbr_in_if.sink    items,
    cldbr_out_if.source cmds
);
    import cldbr_pkg::*;

    localparam int unsigned COL_W = $clog2(COLUMNS);
    localparam int unsigned LEN_W = $clog2(COLUMNS + 1);
    localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(COLUMNS);

    // input register
    logic      in_valid_reg;
    in_item_t  in_data_reg;

    // result register
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_data_reg;
    out_item_t out_data_next;

    // sequencer
    seq_state_t       seq_reg, seq_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic             dirty_reg, dirty_next;

    // buffers
    logic [7:0]       waiting_buf_reg [ROWS][COLUMNS];
    logic [7:0]       active_buf_reg  [ROWS][COLUMNS];
    logic [7:0]       staging_buf_reg [STAGE_LINES][COLUMNS];
    logic [LEN_W-1:0] staging_len_reg [STAGE_LINES];
    logic [LEN_W-1:0] staging_len_next [STAGE_LINES];

    logic [7:0]       formatted [ROWS][COLUMNS];
    logic [LEN_W-1:0] shift_amt [STAGE_LINES];

    logic fire;
    logic commit_en;
    logic load_en;
    logic append_en;

    assign fire        = in_valid_reg && (!out_valid_reg || cmds.ready);
    assign items.ready = !in_valid_reg || fire;
    assign cmds.valid  = out_valid_reg;
    assign cmds.data   = out_data_reg;

    assign append_en = fire && (in_data_reg.mode == MODE_APPEND)
                       && (staging_len_reg[in_data_reg.line_select] < FULL_LEN);
    assign commit_en = fire && (in_data_reg.mode == MODE_COMMIT);

    // centering offset per staged line
    always_comb
    begin
        for (int l = 0; l < STAGE_LINES; l++)
        begin
            if (in_data_reg.center_text && (staging_len_reg[l] < FULL_LEN))
            begin
                shift_amt[l] = (FULL_LEN - staging_len_reg[l]) >> 1;
            end
            else
            begin
                shift_amt[l] = '0;
            end
        end
    end

    // commit formatting: each cell picks its staged character or a blank
    for (genvar r = 0; r < ROWS; r++)
    begin : g_row
        for (genvar c = 0; c < COLUMNS; c++)
        begin : g_col
            if (r < STAGE_LINES)
            begin : g_staged
                logic [LEN_W-1:0] pos;
                assign pos = LEN_W'(c) - shift_amt[r];
                assign formatted[r][c] =
                    ((LEN_W'(c) >= shift_amt[r]) && (pos < staging_len_reg[r]))
                    ? staging_buf_reg[r][pos[COL_W-1:0]] : BLANK;
            end
            else
            begin : g_blank
                assign formatted[r][c] = BLANK;
            end
        end
    end

    always_comb
    begin
        seq_next         = seq_reg;
        cur_row_next     = cur_row_reg;
        cur_col_next     = cur_col_reg;
        dirty_next       = dirty_reg;
        staging_len_next = staging_len_reg;
        load_en          = 1'b0;
        out_valid_next   = out_valid_reg && !cmds.ready;
        out_data_next    = out_data_reg;

        if (fire)
        begin
            out_valid_next = 1'b0;
            unique case (in_data_reg.mode)
                MODE_APPEND:
                begin
                    if (append_en)
                    begin
                        staging_len_next[in_data_reg.line_select] =
                            staging_len_reg[in_data_reg.line_select] + 1'b1;
                    end
                end
                MODE_COMMIT:
                begin
                    for (int l = 0; l < STAGE_LINES; l++)
                    begin
                        staging_len_next[l] = '0;
                    end
                    dirty_next = 1'b1;
                end
                MODE_TICK:
                begin
                    unique case (seq_reg)
                        SEQ_IDLE:
                        begin
                            if (dirty_reg)
                            begin
                                load_en      = 1'b1;
                                dirty_next   = 1'b0;
                                cur_row_next = '0;
                                cur_col_next = '0;
                                seq_next     = SEQ_SET_ROW;
                            end
                        end
                        SEQ_SET_ROW:
                        begin
                            out_valid_next           = 1'b1;
                            out_data_next.cmd_kind   = CMD_SET_CURSOR;
                            out_data_next.cursor_row = cur_row_reg[0];
                            out_data_next.char_out   = '0;
                            seq_next                 = SEQ_WRITE;
                        end
                        SEQ_WRITE:
                        begin
                            out_valid_next           = 1'b1;
                            out_data_next.cmd_kind   = CMD_WRITE_CHAR;
                            out_data_next.cursor_row = 1'b0;
                            out_data_next.char_out   =
                                active_buf_reg[cur_row_reg][cur_col_reg];
                            if (cur_col_reg == LAST_COL)
                            begin
                                cur_col_next = '0;
                                if (cur_row_reg == LAST_ROW)
                                begin
                                    seq_next = SEQ_IDLE;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                    seq_next     = SEQ_SET_ROW;
                                end
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            seq_next = SEQ_IDLE;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            seq_reg       <= SEQ_IDLE;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            dirty_reg     <= 1'b0;
            for (int l = 0; l < STAGE_LINES; l++)
            begin
                staging_len_reg[l] <= '0;
            end
            for (int r = 0; r < ROWS; r++)
            begin
                for (int c = 0; c < COLUMNS; c++)
                begin
                    waiting_buf_reg[r][c] <= BLANK;
                    active_buf_reg[r][c]  <= BLANK;
                end
            end
        end
        else
        begin
            in_valid_reg    <= items.valid || (in_valid_reg && !fire);
            out_valid_reg   <= out_valid_next;
            seq_reg         <= seq_next;
            cur_row_reg     <= cur_row_next;
            cur_col_reg     <= cur_col_next;
            dirty_reg       <= dirty_next;
            staging_len_reg <= staging_len_next;
            if (commit_en)
            begin
                waiting_buf_reg <= formatted;
            end
            if (load_en)
            begin
                active_buf_reg <= waiting_buf_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (items.valid && items.ready)
        begin
            in_data_reg <= items.data;
        end
        out_data_reg <= out_data_next;
        if (append_en)
        begin
            staging_buf_reg[in_data_reg.line_select]
                [staging_len_reg[in_data_reg.line_select][COL_W-1:0]] <=
                in_data_reg.char_code;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_stall_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !fire) |-> (out_valid_reg && !cmds.ready))
        else $error("input stage stalled without a blocked result");

    a_idle_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == SEQ_IDLE) |-> (cur_col_reg == '0))
        else $error("sequencer idle with a nonzero column");

    a_set_row_emits_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (in_data_reg.mode == MODE_TICK) && (seq_reg == SEQ_SET_ROW))
        |=> (out_valid_reg && (out_data_reg.cmd_kind == CMD_SET_CURSOR)
             && (seq_reg == SEQ_WRITE)))
        else $error("set-row tick did not produce a cursor command");

    a_commit_sets_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        commit_en |=> (dirty_reg && (staging_len_reg[0] == '0)))
        else $error("commit did not mark the waiting buffer dirty");

    a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (staging_len_reg[0] <= FULL_LEN) && (staging_len_reg[1] <= FULL_LEN))
        else $error("staging length exceeds line width");

endmodule
